// ----- rtl/imu_offset_calibrator_defines.svh -----
// assertion macros shared by the imu offset calibrator checks
`ifndef IMU_OFFSET_CALIBRATOR_DEFINES_SVH
`define IMU_OFFSET_CALIBRATOR_DEFINES_SVH

// condition implies consequence in the same cycle
`define IOC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("imu offset calibrator check failed");

// condition implies consequence in the next cycle
`define IOC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("imu offset calibrator check failed");

`endif

// ----- rtl/ioc_pkg.sv -----
// types and constants shared by the imu offset calibrator modules
`default_nettype none

package ioc_pkg;

  localparam int NUM_AXES  = 6;
  localparam int SAMPLE_W  = 16;
  localparam int S_TDATA_W = 96;
  localparam int M_TDATA_W = 104;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  // result word layout above the six offsets
  localparam int OUT_SETTLED_LSB = 96;
  localparam int OUT_CAL_BIT     = 99;

  localparam int ONE_G           = 16384;
  localparam int ACCEL_FIRST_DIV = 8;
  localparam int GYRO_FIRST_DIV  = 4;

  localparam logic [2:0] AXIS_AX   = 3'd0;
  localparam logic [2:0] AXIS_AZ   = 3'd2;
  localparam logic [2:0] AXIS_GX   = 3'd3;
  localparam logic [2:0] AXIS_LAST = 3'd5;

  localparam logic [1:0] REG_BATCH_SIZE     = 2'd0;
  localparam logic [1:0] REG_WARMUP_COUNT   = 2'd1;
  localparam logic [1:0] REG_ACCEL_DEADZONE = 2'd2;
  localparam logic [1:0] REG_GYRO_DEADZONE  = 2'd3;

  localparam logic [12:0] RST_BATCH_SIZE     = 13'd1000;
  localparam logic [7:0]  RST_WARMUP_COUNT   = 8'd101;
  localparam logic [7:0]  RST_ACCEL_DEADZONE = 8'd8;
  localparam logic [7:0]  RST_GYRO_DEADZONE  = 8'd1;

  typedef struct packed {
    logic [12:0] batch_size;
    logic [7:0]  warmup_count;
    logic [7:0]  accel_deadzone;
    logic [7:0]  gyro_deadzone;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_WARMUP,
    ST_ACCUM,
    ST_DONE,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_CORR_GO,
    ST_CORR_WAIT,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic       clear;
    logic       warm_inc;
    logic       acc_first;
    logic       acc;
    logic       div_start;
    logic       corr;
    logic       mean_wr;
    logic       corr_wr;
    logic       push;
    logic [2:0] axis;
  } cmd_t;

  typedef struct packed {
    logic warm_done;
    logic last_first;
    logic last_acc;
    logic div_done;
    logic out_free;
    logic done_now;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/ioc_div.sv -----
// shared radix-2 signed divider, one quotient bit per cycle, truncates toward zero
`default_nettype none

module ioc_div #(
  parameter int A_W = 29,
  parameter int D_W = 13
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [A_W-1:0] dividend,
  input  logic        [D_W-1:0] divisor,
  output logic                  done,
  output logic signed [A_W-1:0] quotient
);

  localparam int CNT_W = $clog2(A_W);

  logic             busy;
  logic             fix;
  logic             neg;
  logic [CNT_W-1:0] cnt;
  logic [A_W-1:0]   q;
  logic [D_W-1:0]   d;
  logic [D_W-1:0]   r;
  logic [D_W:0]     r_shift;
  logic [D_W:0]     r_diff;
  logic             ge;

  assign r_shift  = {r, q[A_W-1]};
  assign r_diff   = r_shift - {1'b0, d};
  assign ge       = r_shift >= {1'b0, d};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fix;
      fix  <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  // magnitude division, sign applied in the fix cycle
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend[A_W-1] ? -dividend : dividend;
      neg <= dividend[A_W-1];
      d   <= divisor;
      r   <= '0;
      cnt <= CNT_W'(A_W - 1);
    end else if (busy) begin
      q   <= {q[A_W-2:0], ge};
      r   <= ge ? r_diff[D_W-1:0] : r_shift[D_W-1:0];
      cnt <= cnt - CNT_W'(1);
    end else if (fix && neg) begin
      q <= -q;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ioc_ctrl.sv -----
// controller: sample phases and batch-end sequencing of the shared divider
`default_nettype none

module ioc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             mode,
  input  ioc_pkg::status_t status,
  output logic             s_tready,
  output ioc_pkg::cmd_t    cmd
);

  import ioc_pkg::*;

  state_t     state;
  state_t     state_next;
  logic [2:0] axis;
  logic [2:0] axis_next;
  logic       accept;

  assign s_tready = (state inside {ST_WARMUP, ST_ACCUM, ST_DONE});
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WARMUP;
      axis  <= AXIS_AX;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  always_comb begin
    state_next = state;
    axis_next  = axis;
    case (state)
      ST_WARMUP: begin
        if (accept) begin
          if (mode) begin
            state_next = ST_WARMUP;
          end else if (status.warm_done && status.last_first) begin
            state_next = ST_MEAN_GO;
          end else if (status.warm_done) begin
            state_next = ST_ACCUM;
          end
        end
      end
      ST_ACCUM: begin
        if (accept) begin
          if (mode) begin
            state_next = ST_WARMUP;
          end else if (status.last_acc) begin
            state_next = ST_MEAN_GO;
          end
        end
      end
      ST_DONE: begin
        if (accept && mode) begin
          state_next = ST_WARMUP;
        end
      end
      ST_MEAN_GO: begin
        state_next = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (status.div_done) begin
          if (axis == AXIS_LAST) begin
            axis_next  = AXIS_AX;
            state_next = ST_CORR_GO;
          end else begin
            axis_next  = axis + 3'd1;
            state_next = ST_MEAN_GO;
          end
        end
      end
      ST_CORR_GO: begin
        state_next = ST_CORR_WAIT;
      end
      ST_CORR_WAIT: begin
        if (status.div_done) begin
          if (axis == AXIS_LAST) begin
            axis_next  = AXIS_AX;
            state_next = ST_PUSH;
          end else begin
            axis_next  = axis + 3'd1;
            state_next = ST_CORR_GO;
          end
        end
      end
      ST_PUSH: begin
        if (status.out_free) begin
          state_next = status.done_now ? ST_DONE : ST_WARMUP;
        end
      end
      default: begin
        state_next = ST_WARMUP;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.axis = axis;
    case (state)
      ST_WARMUP: begin
        if (accept) begin
          if (mode) begin
            cmd.clear = 1'b1;
          end else if (status.warm_done) begin
            cmd.acc_first = 1'b1;
          end else begin
            cmd.warm_inc = 1'b1;
          end
        end
      end
      ST_ACCUM: begin
        if (accept) begin
          if (mode) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.acc = 1'b1;
          end
        end
      end
      ST_DONE: begin
        cmd.clear = accept && mode;
      end
      ST_MEAN_GO: begin
        cmd.div_start = 1'b1;
      end
      ST_MEAN_WAIT: begin
        cmd.mean_wr = status.div_done;
      end
      ST_CORR_GO: begin
        cmd.div_start = 1'b1;
        cmd.corr      = 1'b1;
      end
      ST_CORR_WAIT: begin
        cmd.corr    = 1'b1;
        cmd.corr_wr = status.div_done;
      end
      ST_PUSH: begin
        cmd.push = status.out_free;
      end
      default: begin
        cmd.clear = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/ioc_dp.sv -----
// datapath: per-axis sums, offsets, divider operand selection and result register
`default_nettype none

module ioc_dp #(
  parameter int MAX_BATCH = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ioc_pkg::cmd_t                   cmd,
  input  ioc_pkg::cfg_t                   cfg,
  input  logic [ioc_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic                            m_tready,
  output ioc_pkg::status_t                status,
  output logic                            m_tvalid,
  output logic [ioc_pkg::M_TDATA_W-1:0]   m_tdata
);

  import ioc_pkg::*;

  localparam int SUM_W = SAMPLE_W + 1 + $clog2(MAX_BATCH);
  localparam int CNT_W = ($clog2(MAX_BATCH + 1) > 8) ? $clog2(MAX_BATCH + 1) : 8;
  localparam int NB_W  = ($clog2(MAX_BATCH + 1) > 13) ? $clog2(MAX_BATCH + 1) : 13;
  localparam int DVS_W = (CNT_W > 9) ? CNT_W : 9;

  logic        [CNT_W-1:0]    count;
  logic signed [SUM_W-1:0]    sums [NUM_AXES];
  logic        [SAMPLE_W-1:0] offsets [NUM_AXES];
  logic                       first_batch;
  logic        [2:0]          settle_cnt;
  logic                       out_valid;
  logic        [SAMPLE_W-1:0] out_off [NUM_AXES];
  logic        [2:0]          out_settled;
  logic                       out_cal;

  logic signed [SAMPLE_W-1:0] sample [NUM_AXES];
  logic        [NB_W-1:0]     bs_ext;
  logic        [NB_W-1:0]     nb_full;
  logic        [CNT_W-1:0]    nb;
  logic        [CNT_W:0]      count_inc;
  logic        [7:0]          adz_eff;
  logic        [7:0]          dz;
  logic                       is_accel;
  logic        [DVS_W-1:0]    divisor;
  logic signed [SUM_W-1:0]    dividend;
  logic signed [SUM_W-1:0]    quotient;
  logic signed [SUM_W-1:0]    mean_err;
  logic        [SUM_W-1:0]    err_mag;
  logic                       settled;
  logic                       div_done;
  logic                       done_now;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      sample[i] = s_tdata[i*SAMPLE_W +: SAMPLE_W];
    end
  end

  // effective batch length: zero means one, saturate at the maximum
  assign bs_ext  = NB_W'(cfg.batch_size);
  assign nb_full = (cfg.batch_size == '0) ? NB_W'(1) :
                   (bs_ext > NB_W'(MAX_BATCH)) ? NB_W'(MAX_BATCH) : bs_ext;
  assign nb        = nb_full[CNT_W-1:0];
  assign count_inc = {1'b0, count} + (CNT_W + 1)'(1);

  assign adz_eff  = (cfg.accel_deadzone == '0) ? 8'd1 : cfg.accel_deadzone;
  assign is_accel = cmd.axis < AXIS_GX;
  assign dz       = is_accel ? adz_eff : cfg.gyro_deadzone;
  assign dividend = sums[cmd.axis];

  always_comb begin
    if (!cmd.corr) begin
      divisor = DVS_W'(nb);
    end else if (first_batch) begin
      divisor = is_accel ? DVS_W'(ACCEL_FIRST_DIV) : DVS_W'(GYRO_FIRST_DIV);
    end else if (is_accel) begin
      divisor = DVS_W'(adz_eff);
    end else begin
      divisor = DVS_W'({1'b0, cfg.gyro_deadzone} + 9'd1);
    end
  end

  ioc_div #(
    .A_W (SUM_W),
    .D_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // error seen by the correction: one g minus mean on z, minus mean elsewhere
  assign mean_err = (cmd.axis == AXIS_AZ) ? SUM_W'(ONE_G) - quotient : -quotient;
  assign err_mag  = dividend[SUM_W-1] ? -dividend : dividend;
  assign settled  = !first_batch && (err_mag <= SUM_W'(dz));
  assign done_now = !first_batch && (settle_cnt == 3'(NUM_AXES));

  always_comb begin
    status            = '0;
    status.warm_done  = count >= CNT_W'(cfg.warmup_count);
    status.last_first = nb == CNT_W'(1);
    status.last_acc   = count_inc >= {1'b0, nb};
    status.div_done   = div_done;
    status.out_free   = !out_valid || m_tready;
    status.done_now   = done_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count       <= '0;
      first_batch <= 1'b1;
      settle_cnt  <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        sums[i]    <= '0;
        offsets[i] <= '0;
      end
    end else begin
      if (cmd.warm_inc || cmd.acc) begin
        count <= count_inc[CNT_W-1:0];
      end
      if (cmd.acc_first) begin
        count <= CNT_W'(1);
      end
      if (cmd.acc_first || cmd.acc) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          sums[i] <= sums[i] + SUM_W'(sample[i]);
        end
      end
      if (cmd.mean_wr) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          if (3'(i) == cmd.axis) begin
            sums[i] <= mean_err;
          end
        end
      end
      if (cmd.corr_wr) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          if (3'(i) == cmd.axis) begin
            if (first_batch) begin
              offsets[i] <= quotient[SAMPLE_W-1:0];
            end else if (!settled) begin
              offsets[i] <= offsets[i] + quotient[SAMPLE_W-1:0];
            end
          end
        end
        settle_cnt <= ((cmd.axis == AXIS_AX) ? 3'd0 : settle_cnt) + {2'b00, settled};
      end
      if (cmd.push) begin
        first_batch <= 1'b0;
        count       <= '0;
        for (int i = 0; i < NUM_AXES; i++) begin
          sums[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        out_off[i] <= offsets[i];
      end
      out_settled <= settle_cnt;
      out_cal     <= done_now;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_cal, out_settled, out_off[5], out_off[4], out_off[3],
                     out_off[2], out_off[1], out_off[0]};

endmodule

`default_nettype wire

// ----- rtl/imu_offset_calibrator.sv -----
// Six-axis offset calibrator. The input stream takes a sample whenever s_tvalid
// is high while warming up or accumulating. The transfer that completes a batch
// starts the batch-end pass: twelve divisions (six means, then six corrections)
// on one shared radix-2 divider, then the load of the result register; s_tready
// stays low throughout. A result waiting on m_tready does not hold off further
// samples; only a second batch end waits for it. Samples with tuser set restart
// calibration with zeroed offsets; once all axes are settled, plain samples are
// taken and dropped until a restart.
// Registers on the APB port: batch_size at 0x0, warmup_count at 0x4,
// accel_deadzone at 0x8, gyro_deadzone at 0xC; write them only while idle.
`default_nettype none

module imu_offset_calibrator #(
  parameter int MAX_BATCH = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
  input  logic [ioc_pkg::S_TDATA_W-1:0]   s_tdata,
  // mode
  input  logic [0:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // offset_ax, offset_ay, offset_az, offset_gx, offset_gy, offset_gz,
  // axes_settled, calibrated, zero pad
  output logic [ioc_pkg::M_TDATA_W-1:0]   m_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ioc_pkg::PADDR_W-1:0]     paddr,
  input  logic [ioc_pkg::PDATA_W-1:0]     pwdata,
  output logic [ioc_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);

  import ioc_pkg::*;

  cfg_t       cfg;
  cmd_t       cmd;
  status_t    status;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.batch_size     <= RST_BATCH_SIZE;
      cfg.warmup_count   <= RST_WARMUP_COUNT;
      cfg.accel_deadzone <= RST_ACCEL_DEADZONE;
      cfg.gyro_deadzone  <= RST_GYRO_DEADZONE;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BATCH_SIZE:     cfg.batch_size     <= pwdata[12:0];
        REG_WARMUP_COUNT:   cfg.warmup_count   <= pwdata[7:0];
        REG_ACCEL_DEADZONE: cfg.accel_deadzone <= pwdata[7:0];
        REG_GYRO_DEADZONE:  cfg.gyro_deadzone  <= pwdata[7:0];
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BATCH_SIZE:     prdata = PDATA_W'(cfg.batch_size);
      REG_WARMUP_COUNT:   prdata = PDATA_W'(cfg.warmup_count);
      REG_ACCEL_DEADZONE: prdata = PDATA_W'(cfg.accel_deadzone);
      REG_GYRO_DEADZONE:  prdata = PDATA_W'(cfg.gyro_deadzone);
      default:            prdata = '0;
    endcase
  end

  ioc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .mode     (s_tuser[0]),
    .status   (status),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  ioc_dp #(
    .MAX_BATCH (MAX_BATCH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .s_tdata  (s_tdata),
    .m_tready (m_tready),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

// ----- rtl/ioc_checker.sv -----
// port-level checks for the imu offset calibrator, bound to the top level
`default_nettype none
`include "imu_offset_calibrator_defines.svh"

module ioc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [ioc_pkg::M_TDATA_W-1:0] m_tdata
);

  import ioc_pkg::*;

  // a result only appears after the batch-end pass, which holds off samples
  `IOC_ASSERT_NOW(a_result_after_stall, clk, rst, $rose(m_tvalid), $past(!s_tready))

  `IOC_ASSERT_NEXT(a_result_held, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  `IOC_ASSERT_NOW(a_settled_range, clk, rst, m_tvalid, m_tdata[OUT_SETTLED_LSB +: 3] <= 3'd6)

  // calibrated is only reported with every axis inside its deadzone
  `IOC_ASSERT_NOW(a_cal_all_settled, clk, rst, m_tvalid && m_tdata[OUT_CAL_BIT], m_tdata[OUT_SETTLED_LSB +: 3] == 3'd6)

endmodule

bind imu_offset_calibrator ioc_checker u_ioc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
